### design/software_timer_table_assert.svh
// Assertion macros shared by the timer table RTL.
// Define ASSERT_OFF to compile all checks away.
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising clock edge outside reset.
`define STT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer table assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer table assertion failed");

`else

`define STT_ASSERT_IMP(label, clk, rst, ante, cons)
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/sttbl_pkg.sv
package sttbl_pkg;

   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 4;
   localparam int TICK_W   = 32;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [TICK_W-1:0]   tick_type;

   localparam action_type ACT_TICK     = 3'd0;
   localparam action_type ACT_REGISTER = 3'd1;
   localparam action_type ACT_WRITE    = 3'd2;
   localparam action_type ACT_START    = 3'd3;
   localparam action_type ACT_STOP     = 3'd4;
   localparam action_type ACT_REMOVE   = 3'd5;

endpackage

### design/software_timer_table.sv
// Table of one-shot software timers driven by a 32-bit tick count. Each
// transfer on the request side (start high while busy is low) carries one
// action: tick, register a slot, write its expiry, start, stop or remove it.
// A tick adds one to the count and then walks the slots in ascending order
// with a single 32-bit comparator; every present, armed slot whose expiry is
// at or below the new count is disarmed and reported as its own result. A
// tick that fires nothing gives one empty result. Every other action gives
// exactly one result. Results appear on the rsp_ ports for one cycle, marked
// by rsp_strobe, and cannot be held off, so the receiver must take each one
// as it comes; rsp_last marks the final result of an action. A tick keeps
// busy high until its scan ends; the expiry values sit in a RAM with one
// registered read port that the scan reads one slot per cycle. Start reads
// its expiry from the RAM, then compares it with the tick count. Other
// codes (register, write expiry, stop, remove, unused) leave busy low and
// answer in the next cycle. The expiry RAM needs no clearing pass: a
// per-slot valid bit makes an unwritten or re-registered slot read as zero.
module software_timer_table #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sttbl_pkg::action_type req_action,
   input  sttbl_pkg::slot_type   req_slot,
   input  sttbl_pkg::tick_type   req_new_expiry,
   output logic                rsp_strobe,
   output logic                rsp_fired,
   output sttbl_pkg::slot_type   rsp_fired_slot,
   output sttbl_pkg::tick_type   rsp_tick_now,
   output logic                rsp_armed_now,
   output logic                rsp_last
);

   import sttbl_pkg::*;

   `include "software_timer_table_assert.svh"

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;

   // Control state.
   logic [1:0]             state_ff,   state_in;
   tick_type               tick_ff,    tick_in;
   logic [TIMER_SLOTS-1:0] armed_ff,   armed_in;
   logic [TIMER_SLOTS-1:0] present_ff, present_in;
   logic [TIMER_SLOTS-1:0] exp_vld_ff, exp_vld_in;
   logic [CNT_W-1:0]       issue_ff,   issue_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic                   hold_vld_ff, hold_vld_in;
   logic                   strobe_ff,  strobe_in;

   // Payload registers.
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [IDX_W-1:0]       hold_idx_ff, hold_idx_in;
   slot_type               op_slot_ff,  op_slot_in;
   logic                   fired_ff,    fired_in;
   slot_type               fslot_ff,    fslot_in;
   logic                   armed_now_ff, armed_now_in;
   logic                   last_ff,     last_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_raddr;
   tick_type               ram_q;
   tick_type               exp_rd;
   logic [IDX_W-1:0]       req_idx;
   logic                   in_range;
   logic                   accept;
   logic                   scan_issue;
   logic                   exp_due;
   logic                   hit;

   sttbl_ram #(
      .WIDTH  (TICK_W),
      .DEPTH  (TIMER_SLOTS),
      .ADDR_W (IDX_W)
   ) u_expiry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_idx),
      .wr_data (req_new_expiry),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign req_idx  = IDX_W'(req_slot);
   assign in_range = (32'(req_slot) < 32'(TIMER_SLOTS));
   assign accept   = start && (state_ff == ST_IDLE);
   assign busy     = (state_ff != ST_IDLE);

   // A slot whose expiry was never written since it was registered reads zero.
   assign exp_rd = exp_vld_ff[rd_idx_ff] ? ram_q : '0;

   // The one comparator: the scan fires on it, start arms on its inverse.
   assign exp_due = (exp_rd <= tick_ff);

   assign scan_issue = (state_ff == ST_SCAN) && (issue_ff < SLOTS_C);
   assign hit = (state_ff == ST_SCAN) && cmp_vld_ff && present_ff[rd_idx_ff]
                && armed_ff[rd_idx_ff] && exp_due;

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      armed_in     = armed_ff;
      present_in   = present_ff;
      exp_vld_in   = exp_vld_ff;
      issue_in     = issue_ff;
      cmp_vld_in   = 1'b0;
      hold_vld_in  = hold_vld_ff;
      hold_idx_in  = hold_idx_ff;
      op_slot_in   = op_slot_ff;
      strobe_in    = 1'b0;
      fired_in     = 1'b0;
      fslot_in     = fslot_ff;
      armed_now_in = 1'b0;
      last_in      = 1'b0;
      ram_we       = 1'b0;
      ram_raddr    = req_idx;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_TICK) begin
                  tick_in     = tick_ff + 1'b1;
                  issue_in    = '0;
                  hold_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end else if (in_range && (req_action == ACT_START)) begin
                  // The expiry is read at this edge and compared next cycle.
                  op_slot_in = req_slot;
                  state_in   = ST_START;
               end else begin
                  strobe_in = 1'b1;
                  last_in   = 1'b1;
                  fslot_in  = req_slot;
                  if (in_range) begin
                     case (req_action)
                        ACT_REGISTER: begin
                           armed_in[req_idx]   = 1'b0;
                           present_in[req_idx] = 1'b1;
                           exp_vld_in[req_idx] = 1'b0;
                           armed_now_in        = 1'b0;
                        end
                        ACT_WRITE: begin
                           ram_we              = 1'b1;
                           exp_vld_in[req_idx] = 1'b1;
                           armed_now_in        = armed_ff[req_idx];
                        end
                        ACT_STOP: begin
                           armed_in[req_idx] = 1'b0;
                           armed_now_in      = 1'b0;
                        end
                        ACT_REMOVE: begin
                           present_in[req_idx] = 1'b0;
                           armed_now_in        = armed_ff[req_idx];
                        end
                        default: begin
                           armed_now_in = armed_ff[req_idx];
                        end
                     endcase
                  end
               end
            end
         end

         ST_START: begin
            armed_in[rd_idx_ff] = !exp_due;
            strobe_in           = 1'b1;
            last_in             = 1'b1;
            fslot_in            = op_slot_ff;
            armed_now_in        = !exp_due;
            state_in            = ST_IDLE;
         end

         ST_SCAN: begin
            if (scan_issue) begin
               ram_raddr  = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
            if (hit) begin
               // One firing is held back so that the final one can carry last.
               armed_in[rd_idx_ff] = 1'b0;
               if (hold_vld_ff) begin
                  strobe_in = 1'b1;
                  fired_in  = 1'b1;
                  fslot_in  = SLOT_W'(hold_idx_ff);
                  last_in   = 1'b0;
               end
               hold_vld_in = 1'b1;
               hold_idx_in = rd_idx_ff;
            end
            if (!scan_issue && !cmp_vld_ff) begin
               // Scan finished: release the held firing, or an empty result.
               strobe_in   = 1'b1;
               last_in     = 1'b1;
               fired_in    = hold_vld_ff;
               fslot_in    = hold_vld_ff ? SLOT_W'(hold_idx_ff) : '0;
               hold_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tick_ff     <= '0;
         armed_ff    <= '0;
         present_ff  <= '0;
         exp_vld_ff  <= '0;
         issue_ff    <= '0;
         cmp_vld_ff  <= 1'b0;
         hold_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tick_ff     <= tick_in;
         armed_ff    <= armed_in;
         present_ff  <= present_in;
         exp_vld_ff  <= exp_vld_in;
         issue_ff    <= issue_in;
         cmp_vld_ff  <= cmp_vld_in;
         hold_vld_ff <= hold_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= ram_raddr;
      hold_idx_ff  <= hold_idx_in;
      op_slot_ff   <= op_slot_in;
      fired_ff     <= fired_in;
      fslot_ff     <= fslot_in;
      armed_now_ff <= armed_now_in;
      last_ff      <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_fired      = fired_ff;
   assign rsp_fired_slot = fslot_ff;
   assign rsp_tick_now   = tick_ff;
   assign rsp_armed_now  = armed_now_ff;
   assign rsp_last       = last_ff;

   // A firing can only come out of the slot scan.
   `STT_ASSERT_IMP(a_fired_from_scan, clock, reset, rsp_strobe && rsp_fired,
      $past(state_ff) == ST_SCAN)

   // Actions other than tick and an in-range start answer in the very next cycle with a final result.
   `STT_ASSERT_NEXT(a_quick_answer, clock, reset,
      accept && (req_action != ACT_TICK) && !(in_range && (req_action == ACT_START)),
      rsp_strobe && rsp_last)

   // A held firing never outlives the scan that found it.
   `STT_ASSERT_IMP(a_hold_in_scan, clock, reset, hold_vld_ff, state_ff == ST_SCAN)

   // A reported timer has been disarmed.
   `STT_ASSERT_IMP(a_fired_disarmed, clock, reset, rsp_strobe && rsp_fired,
      !armed_ff[IDX_W'(rsp_fired_slot)])

endmodule

### design/sttbl_ram.sv
module sttbl_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### tb/software_timer_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the timer table, keeps its own copy of the table
// and compares every result transfer with the oldest expected one.
module software_timer_table_checker #(
   parameter int TIMER_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  sttbl_pkg::action_type req_action,
   input  sttbl_pkg::slot_type   req_slot,
   input  sttbl_pkg::tick_type   req_new_expiry,
   input  logic                  rsp_strobe,
   input  logic                  rsp_fired,
   input  sttbl_pkg::slot_type   rsp_fired_slot,
   input  sttbl_pkg::tick_type   rsp_tick_now,
   input  logic                  rsp_armed_now,
   input  logic                  rsp_last,
   output int                    fail_count,
   output int                    outstanding,
   output int                    results_checked,
   output int                    firings_seen
);

   import sttbl_pkg::*;

   typedef struct packed {
      logic     fired;
      slot_type slot;
      tick_type tick;
      logic     armed;
      logic     last;
   } timer_result_type;

   tick_type         tick_model;
   tick_type         expiry_model  [TIMER_SLOTS];
   logic             armed_model   [TIMER_SLOTS];
   logic             present_model [TIMER_SLOTS];
   timer_result_type expected_q [$];
   int               errors   = 0;
   int               checked  = 0;
   int               firings  = 0;

   // Applies one accepted action to the table copy and queues its results.
   task automatic predict_action(input action_type act, input slot_type s,
                                 input tick_type value);
      int               hits;
      logic             armed;
      timer_result_type tail;
      hits  = 0;
      armed = 1'b0;
      if (act == ACT_TICK) begin
         tick_model = tick_model + 1'b1;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (present_model[i] && armed_model[i] && expiry_model[i] <= tick_model) begin
               armed_model[i] = 1'b0;
               expected_q.push_back('{1'b1, slot_type'(i), tick_model, 1'b0, 1'b0});
               hits++;
            end
         end
         if (hits == 0) begin
            expected_q.push_back('{1'b0, slot_type'(0), tick_model, 1'b0, 1'b1});
         end else begin
            tail      = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
         end
      end else begin
         if (int'(s) < TIMER_SLOTS) begin
            case (act)
               ACT_REGISTER: begin
                  expiry_model[s]  = '0;
                  armed_model[s]   = 1'b0;
                  present_model[s] = 1'b1;
               end
               ACT_WRITE:  expiry_model[s] = value;
               ACT_START:  armed_model[s] = (expiry_model[s] > tick_model);
               ACT_STOP:   armed_model[s] = 1'b0;
               ACT_REMOVE: present_model[s] = 1'b0;
               default: ;
            endcase
            armed = armed_model[s];
         end
         expected_q.push_back('{1'b0, s, tick_model, armed, 1'b1});
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         tick_model = '0;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            expiry_model[i]  = '0;
            armed_model[i]   = 1'b0;
            present_model[i] = 1'b0;
         end
         expected_q.delete();
      end else begin
         // A result always belongs to an earlier transfer, so it is checked
         // before the transfer taken at this same edge is predicted.
         if (rsp_strobe) begin
            checked++;
            if (rsp_fired) firings++;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result, fired %0b slot %0d tick %0h", $time,
                        rsp_fired, rsp_fired_slot, rsp_tick_now);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("fired", want.fired, rsp_fired);
               check_field("fired_slot", want.slot, rsp_fired_slot);
               check_field("tick_now", want.tick, rsp_tick_now);
               check_field("armed_now", want.armed, rsp_armed_now);
               check_field("last", want.last, rsp_last);
            end
         end
         if (start && !busy) begin
            predict_action(req_action, req_slot, req_new_expiry);
         end
      end
      outstanding     <= expected_q.size();
      fail_count      <= errors;
      results_checked <= checked;
      firings_seen    <= firings;
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the timer table. The checker instantiated beside
// the block does all prediction and comparison; this module only drives
// request transfers and decides pass or fail at the end.
module tb_top;

   import sttbl_pkg::*;

   localparam int TIMER_SLOTS = 16;

   // The two action codes that the block must treat as no-ops.
   localparam action_type ACT_SPARE6 = 3'd6;
   localparam action_type ACT_SPARE7 = 3'd7;

   localparam int RANDOM_ITEMS = 300;
   localparam int QUIET_TAIL   = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   action_type req_action     = ACT_TICK;
   slot_type   req_slot       = '0;
   tick_type   req_new_expiry = '0;
   logic       rsp_strobe;
   logic       rsp_fired;
   slot_type   rsp_fired_slot;
   tick_type   rsp_tick_now;
   logic       rsp_armed_now;
   logic       rsp_last;

   int fail_count;
   int outstanding;
   int results_checked;
   int firings_seen;

   // Stimulus-side view of the tick count, used only to aim expiry values
   // near the present so that timers actually fire.
   tick_type ticks_sent  = '0;
   int       items_sent  = 0;
   int       cycle_count = 0;
   bit       idling_enabled = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   software_timer_table #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_slot       (req_slot),
      .req_new_expiry (req_new_expiry),
      .rsp_strobe     (rsp_strobe),
      .rsp_fired      (rsp_fired),
      .rsp_fired_slot (rsp_fired_slot),
      .rsp_tick_now   (rsp_tick_now),
      .rsp_armed_now  (rsp_armed_now),
      .rsp_last       (rsp_last)
   );

   software_timer_table_checker #(
      .TIMER_SLOTS(TIMER_SLOTS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_slot        (req_slot),
      .req_new_expiry  (req_new_expiry),
      .rsp_strobe      (rsp_strobe),
      .rsp_fired       (rsp_fired),
      .rsp_fired_slot  (rsp_fired_slot),
      .rsp_tick_now    (rsp_tick_now),
      .rsp_armed_now   (rsp_armed_now),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .firings_seen    (firings_seen)
   );

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results still expected",
                  cycle_count, outstanding);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Drives one request and holds it until the transfer happens. When idling
   // is enabled, a random burst of idle cycles may come first. Start is only
   // lowered in a step where it is not also raised, so back-to-back transfers
   // keep it high throughout.
   task automatic send_item(input action_type act, input slot_type s,
                            input tick_type value);
      int gap;
      if (idling_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_action     <= act;
      req_slot       <= s;
      req_new_expiry <= value;
      start          <= 1'b1;
      // Busy is read right after the edge, i.e. the value it had at the edge.
      do @(posedge clock); while (busy);
      items_sent++;
      if (act == ACT_TICK) ticks_sent = ticks_sent + 1'b1;
   endtask

   // Holds the request side quiet until every expected result has arrived.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Picks an expiry for a freshly written slot: mostly a few ticks ahead,
   // sometimes exactly now (start must refuse it), in the past, or anywhere.
   function automatic tick_type pick_expiry();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return tick_type'($urandom());
      if (sel == 1) return ticks_sent;
      if (sel == 2) return ticks_sent - tick_type'($urandom_range(1, 5));
      return ticks_sent + tick_type'($urandom_range(1, 10));
   endfunction

   initial begin
      slot_type s;
      int       pick;
      int       random_target;
      bit       quiet_stretch;
      bit       mass_done;

      quiet_stretch = 1'b0;
      mass_done     = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A tick on an empty table gives the single empty result.
      send_item(ACT_TICK, 4'd0, '0);
      // An expiry of zero is already behind the count, so start leaves it idle.
      send_item(ACT_REGISTER, 4'd0, '0);
      send_item(ACT_WRITE, 4'd0, '0);
      send_item(ACT_START, 4'd0, '0);
      // The top slot with the largest expiry arms and stays armed.
      send_item(ACT_REGISTER, 4'd15, '0);
      send_item(ACT_WRITE, 4'd15, 32'hFFFF_FFFF);
      send_item(ACT_START, 4'd15, '0);
      // Two slots due on the same tick must fire in ascending slot order.
      send_item(ACT_REGISTER, 4'd3, '0);
      send_item(ACT_WRITE, 4'd3, ticks_sent + 2);
      send_item(ACT_START, 4'd3, '0);
      send_item(ACT_REGISTER, 4'd5, '0);
      send_item(ACT_WRITE, 4'd5, ticks_sent + 2);
      send_item(ACT_START, 4'd5, '0);
      // A stopped slot must not fire.
      send_item(ACT_REGISTER, 4'd7, '0);
      send_item(ACT_WRITE, 4'd7, ticks_sent + 1);
      send_item(ACT_START, 4'd7, '0);
      send_item(ACT_STOP, 4'd7, '0);
      // A removed slot keeps its armed mark but drops out of the scan.
      send_item(ACT_REGISTER, 4'd9, '0);
      send_item(ACT_WRITE, 4'd9, ticks_sent + 1);
      send_item(ACT_START, 4'd9, '0);
      send_item(ACT_REMOVE, 4'd9, '0);
      // Write and start act on a slot that was never registered; it stays silent.
      send_item(ACT_WRITE, 4'd12, ticks_sent + 1);
      send_item(ACT_START, 4'd12, '0);
      // An expiry equal to the current count is not strictly ahead: no arm.
      send_item(ACT_WRITE, 4'd0, ticks_sent);
      send_item(ACT_START, 4'd0, '0);
      send_item(ACT_TICK, 4'd0, '0);
      send_item(ACT_TICK, 4'd0, '0);
      // Registering the removed slot again clears its leftover armed mark.
      send_item(ACT_REGISTER, 4'd9, '0);
      // Unused action codes change nothing.
      send_item(ACT_SPARE6, 4'd10, 32'h5555_AAAA);
      send_item(ACT_SPARE7, 4'd1, 32'hAAAA_5555);

      // Random part: mostly well-formed timer lifecycles with random slots and
      // expiry values, interleaved with bursts of ticks and some plain noise.
      random_target = items_sent + RANDOM_ITEMS;
      while (items_sent < random_target) begin
         if ($urandom_range(0, 9) == 0) quiet_stretch = !quiet_stretch;
         idling_enabled = !quiet_stretch && (items_sent < random_target - QUIET_TAIL);

         if (!mass_done && items_sent >= random_target - RANDOM_ITEMS / 2) begin
            // Let everything settle, then arm every slot for the same tick so
            // that one tick reports the whole table.
            mass_done = 1'b1;
            drain();
            for (int i = 0; i < TIMER_SLOTS; i++) begin
               send_item(ACT_REGISTER, slot_type'(i), '0);
               send_item(ACT_WRITE, slot_type'(i), ticks_sent + 3);
               send_item(ACT_START, slot_type'(i), '0);
            end
            repeat (3) send_item(ACT_TICK, 4'd0, tick_type'($urandom()));
         end

         pick = $urandom_range(0, 99);
         s    = slot_type'($urandom_range(0, TIMER_SLOTS - 1));
         if (pick < 55) begin
            if ($urandom_range(0, 2) == 0) send_item(ACT_REGISTER, s, tick_type'($urandom()));
            send_item(ACT_WRITE, s, pick_expiry());
            send_item(ACT_START, s, tick_type'($urandom()));
            if ($urandom_range(0, 9) == 0) send_item(ACT_STOP, s, '0);
            else if ($urandom_range(0, 19) == 0) send_item(ACT_REMOVE, s, '0);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 4)) send_item(ACT_TICK, s, tick_type'($urandom()));
         end else begin
            send_item(action_type'($urandom_range(0, 7)), s, tick_type'($urandom()));
         end
      end

      drain();
      repeat (TIMER_SLOTS + 8) @(posedge clock);

      $display("Summary: %0d request transfers (%0d ticks), %0d results checked, %0d firings.",
               items_sent, ticks_sent, results_checked, firings_seen);
      $display("Covered lifecycles, stop, remove, spare codes and a tick firing all %0d slots.",
               TIMER_SLOTS);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
